// ===== sv/spqb_pkg.sv =====
// Shared types, constants and sine tables for the sprite quad batcher.
// No dependencies; every other file imports this package.
package spqb_pkg;

  localparam int COORD_W    = 24;
  localparam int MAX_QUADS  = 16;
  localparam int QUAD_W     = $clog2(MAX_QUADS + 1);
  localparam int SINE_BITS  = 10;
  localparam int SINE_ENTRIES = 1 << SINE_BITS;
  localparam int SLOT_W     = 10;
  localparam int CNT_W      = 11;
  localparam int TEX_W      = 16;

  localparam logic [1:0] IK_DRAW    = 2'd0;
  localparam logic [1:0] IK_OFFSET  = 2'd1;
  localparam logic [1:0] IK_FLUSH   = 2'd2;
  localparam logic [1:0] IK_UNKNOWN = 2'd3;

  localparam logic [1:0] RK_VERTEX = 2'd0;
  localparam logic [1:0] RK_INDEX  = 2'd1;
  localparam logic [1:0] RK_FLUSH  = 2'd2;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;

  typedef logic signed [15:0] sine_tab_t [SINE_ENTRIES];

  // t * a^2 in Q30; both operands are non-negative, so the shift is a floor divide
  function automatic longint taylor_sq(longint t, longint a);
    return (((t * a) >>> 30) * a) >>> 30;
  endfunction

  // Q14 sine of a Q30 angle in [0, 2.5 pi) by an eight-term Taylor series;
  // evaluated at elaboration only, to fill the tables
  function automatic logic signed [15:0] sin_q14(longint ang);
    longint a;
    longint t;
    longint s;
    bit     neg;
    a   = ang;
    neg = 1'b0;
    if (a >= Q30_TWO_PI) a = a - Q30_TWO_PI;
    if (a > Q30_PI) begin
      a   = a - Q30_PI;
      neg = 1'b1;
    end
    if (a > Q30_HALF_PI) a = Q30_PI - a;
    if (a < 0) a = 0;
    t = a;
    s = a;
    t = taylor_sq(t, a) / 64'sd6;
    s = s - t;
    t = taylor_sq(t, a) / 64'sd20;
    s = s + t;
    t = taylor_sq(t, a) / 64'sd42;
    s = s - t;
    t = taylor_sq(t, a) / 64'sd72;
    s = s + t;
    t = taylor_sq(t, a) / 64'sd110;
    s = s - t;
    t = taylor_sq(t, a) / 64'sd156;
    s = s + t;
    t = taylor_sq(t, a) / 64'sd210;
    s = s - t;
    if (s < 0) s = 0;
    s = (s + 32768) >>> 16;
    return neg ? 16'(-s) : 16'(s);
  endfunction

  function automatic sine_tab_t build_tab(bit cosine);
    sine_tab_t tab;
    longint    ang;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      ang    = (longint'(i) * Q30_TWO_PI) >>> SINE_BITS;
      tab[i] = sin_q14(cosine ? ang + Q30_HALF_PI : ang);
    end
    return tab;
  endfunction

  localparam sine_tab_t SIN_TAB = build_tab(1'b0);
  localparam sine_tab_t COS_TAB = build_tab(1'b1);

  function automatic logic [1:0] tri_corner(logic [2:0] i);
    logic [1:0] c;
    unique case (i)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd0;
      3'd4:    c = 2'd2;
      3'd5:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic               load_off;
    logic               load;
    logic               prep;
    logic               mul;
    logic               add;
    logic               rot;
    logic               out_vtx;
    logic               out_idx;
    logic               out_flush;
    logic               last;
    logic [1:0]         corner;
    logic [SLOT_W-1:0]  slot;
    logic [TEX_W-1:0]   flush_tex;
    logic [CNT_W-1:0]   flush_cnt;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ===== sv/spqb_if.sv =====
// Valid/ready channel interfaces for draw items and result items.
// Depends on spqb_pkg.
interface spqb_in_if import spqb_pkg::*; (input logic clk);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [TEX_W-1:0]           texture_id;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic signed [COORD_W-1:0]  pos_z;
  logic [15:0]                size_w;
  logic [15:0]                size_h;
  logic [15:0]                scale;
  logic [15:0]                rotation;
  logic [1:0]                 corner;
  logic signed [COORD_W-1:0]  offset_x;
  logic signed [COORD_W-1:0]  offset_y;
  modport source (output valid, kind, texture_id, pos_x, pos_y, pos_z, size_w, size_h,
                  scale, rotation, corner, offset_x, offset_y, input ready);
  modport sink (input valid, kind, texture_id, pos_x, pos_y, pos_z, size_w, size_h,
                scale, rotation, corner, offset_x, offset_y, output ready);
endinterface

interface spqb_out_if import spqb_pkg::*; (input logic clk);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 result_kind;
  logic signed [COORD_W-1:0]  vertex_x;
  logic signed [COORD_W-1:0]  vertex_y;
  logic signed [COORD_W-1:0]  vertex_z;
  logic                       tex_u;
  logic                       tex_v;
  logic [SLOT_W-1:0]          slot;
  logic [TEX_W-1:0]           batch_texture;
  logic [CNT_W-1:0]           index_count;
  logic                       last;
  modport source (output valid, result_kind, vertex_x, vertex_y, vertex_z, tex_u, tex_v,
                  slot, batch_texture, index_count, last, input ready);
  modport sink (input valid, result_kind, vertex_x, vertex_y, vertex_z, tex_u, tex_v,
                slot, batch_texture, index_count, last, output ready);
endinterface

// ===== sv/sprite_quad_batcher.sv =====
// Sprite quad batcher: turns draw items into vertex and index transactions.
// Instantiates spqb_ctrl and spqb_dp; depends on spqb_pkg and spqb_if.
// Takes one item at a time. An offset load leaves the block ready for the next item; a
// flush item gives one flush transaction; a draw gives four vertices and six indices
// (plus a leading flush on a texture change or when the batch holds sixteen quads).
// A draw runs through the set-up step, then each corner in turn through the shared
// offset multiply, add and rotate steps and its vertex emit, then the index emits; a
// leading flush comes before the set-up step. Every emit waits on the single result
// register, so receiver stalls hold the sequence.
module sprite_quad_batcher import spqb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  spqb_in_if.sink    item,
  spqb_out_if.source result
);

  cmd_t    cmd;
  status_t status;

  spqb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .item_kind  (item.kind),
    .item_tex   (item.texture_id),
    .status     (status),
    .cmd        (cmd)
  );

  spqb_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cmd    (cmd),
    .status (status)
  );

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.out_vtx, cmd.out_idx, cmd.out_flush}))
    else $error("more than one result loaded in a cycle");

  a_flush_busy: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready && item.kind == IK_FLUSH |=> !item.ready)
    else $error("flush item did not occupy the block");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_vtx || cmd.out_idx || cmd.out_flush) |-> (!result.valid || result.ready))
    else $error("result register overwritten while held");

  a_flush_slot: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.result_kind == RK_FLUSH |-> result.slot == '0)
    else $error("flush transaction carries a slot");

endmodule

// ===== sv/spqb_ctrl.sv =====
// Sequencer: batch state, flush decisions and the order of result transactions.
// Depends on spqb_pkg; drives the datapath through cmd_t.
module spqb_ctrl import spqb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic [1:0]       item_kind,
  input  logic [TEX_W-1:0] item_tex,
  input  status_t          status,
  output cmd_t             cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_FLUSH = 8'b0000_0010,
    ST_PREP  = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_ADD   = 8'b0001_0000,
    ST_ROT   = 8'b0010_0000,
    ST_VTX   = 8'b0100_0000,
    ST_IDX   = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [QUAD_W-1:0] quads;
  logic [TEX_W-1:0]  cur_tex;
  logic [TEX_W-1:0]  draw_tex;
  logic              draw_pending;
  logic [1:0]        corner;
  logic [2:0]        idx;
  logic              accept;
  logic              need_flush;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign need_flush = ((quads != '0) && (cur_tex != item_tex)) ||
                      (quads >= QUAD_W'(MAX_QUADS));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item_kind == IK_FLUSH) state_next = ST_FLUSH;
          else if (item_kind == IK_DRAW) state_next = need_flush ? ST_FLUSH : ST_PREP;
        end
      end
      ST_FLUSH: if (status.out_free) state_next = draw_pending ? ST_PREP : ST_IDLE;
      ST_PREP:  state_next = ST_MUL;
      ST_MUL:   state_next = ST_ADD;
      ST_ADD:   state_next = ST_ROT;
      ST_ROT:   state_next = ST_VTX;
      ST_VTX:   if (status.out_free) state_next = (corner == 2'd3) ? ST_IDX : ST_MUL;
      ST_IDX:   if (status.out_free && idx == 3'd5) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.load_off  = accept && (item_kind == IK_OFFSET);
    cmd.load      = accept && (item_kind == IK_DRAW);
    cmd.prep      = (state == ST_PREP);
    cmd.mul       = (state == ST_MUL);
    cmd.add       = (state == ST_ADD);
    cmd.rot       = (state == ST_ROT);
    cmd.corner    = corner;
    cmd.flush_tex = cur_tex;
    cmd.flush_cnt = CNT_W'(quads) * CNT_W'(6);
    unique case (state)
      ST_FLUSH: begin
        cmd.out_flush = status.out_free;
        cmd.last      = !draw_pending;
      end
      ST_VTX: begin
        cmd.out_vtx = status.out_free;
        cmd.slot    = SLOT_W'({quads, corner});
      end
      ST_IDX: begin
        cmd.out_idx = status.out_free;
        cmd.slot    = SLOT_W'({quads, tri_corner(idx)});
        cmd.last    = (idx == 3'd5);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      quads        <= '0;
      cur_tex      <= '0;
      draw_pending <= 1'b0;
      corner       <= '0;
      idx          <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        draw_pending <= (item_kind == IK_DRAW);
        draw_tex     <= item_tex;
      end
      if (cmd.out_flush) begin
        quads   <= '0;
        cur_tex <= '0;
      end
      if (cmd.prep) corner <= '0;
      if (cmd.out_vtx) begin
        corner <= corner + 2'd1;
        idx    <= '0;
      end
      if (cmd.out_idx) begin
        idx <= idx + 3'd1;
        if (idx == 3'd5) begin
          quads        <= quads + QUAD_W'(1);
          cur_tex      <= draw_tex;
          draw_pending <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sv/spqb_dp.sv =====
// Datapath: corner offsets, size scaling, rotation and the result register.
// Depends on spqb_pkg and spqb_if; steered by spqb_ctrl through cmd_t.
module spqb_dp import spqb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  spqb_in_if.sink   item,
  spqb_out_if.source result,
  input  cmd_t      cmd,
  output status_t   status
);

  localparam logic signed [38:0] SAT_HI = 39'sd8388607;
  localparam logic signed [38:0] SAT_LO = -39'sd8388608;

  logic signed [COORD_W-1:0] off_x [4];
  logic signed [COORD_W-1:0] off_y [4];

  logic signed [COORD_W-1:0] px, py, pz;
  logic [15:0]               sc;
  logic [SINE_BITS-1:0]      ang;
  logic [30:0]               hw, hh;
  logic signed [15:0]        sn, cs;
  logic signed [32:0]        ofs_x, ofs_y;
  logic signed [34:0]        dx, dy;
  logic signed [50:0]        p_xc, p_ys, p_xs, p_yc;
  logic [16:0]               sc_eff;
  logic signed [40:0]        prod_x, prod_y;
  logic signed [34:0]        hw_s, hh_s;
  logic signed [51:0]        sum_x, sum_y;
  logic signed [38:0]        rx, ry;
  logic signed [COORD_W-1:0] sat_x, sat_y;

  logic                      ovalid;
  logic [1:0]                o_kind;
  logic signed [COORD_W-1:0] o_x, o_y, o_z;
  logic                      o_u, o_v, o_last;
  logic [SLOT_W-1:0]         o_slot;
  logic [TEX_W-1:0]          o_tex;
  logic [CNT_W-1:0]          o_cnt;

  assign status.out_free = !ovalid || result.ready;

  assign sc_eff = (item.scale == 16'd0) ? 17'd256 : {1'b0, item.scale};
  assign prod_x = off_x[cmd.corner] * $signed({1'b0, sc});
  assign prod_y = off_y[cmd.corner] * $signed({1'b0, sc});
  assign hw_s   = $signed({4'd0, hw});
  assign hh_s   = $signed({4'd0, hh});

  assign sum_x = 52'(p_xc) - 52'(p_ys) + 52'sd8192;
  assign sum_y = 52'(p_xs) + 52'(p_yc) + 52'sd8192;
  assign rx    = 39'(sum_x >>> 14) + 39'(px);
  assign ry    = 39'(sum_y >>> 14) + 39'(py);
  assign sat_x = (rx > SAT_HI) ? COORD_W'(SAT_HI) : (rx < SAT_LO) ? COORD_W'(SAT_LO) :
                 COORD_W'(rx);
  assign sat_y = (ry > SAT_HI) ? COORD_W'(SAT_HI) : (ry < SAT_LO) ? COORD_W'(SAT_LO) :
                 COORD_W'(ry);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        off_x[i] <= '0;
        off_y[i] <= '0;
      end
    end else if (cmd.load_off) begin
      off_x[item.corner] <= item.offset_x;
      off_y[item.corner] <= item.offset_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px  <= item.pos_x;
      py  <= item.pos_y;
      pz  <= item.pos_z;
      sc  <= item.scale;
      ang <= item.rotation[15 -: SINE_BITS];
      // scaled half sizes; a zero scale keeps the size
      hw  <= 31'((33'(item.size_w) * 33'(sc_eff)) >> 1);
      hh  <= 31'((33'(item.size_h) * 33'(sc_eff)) >> 1);
    end
    if (cmd.prep) begin
      sn <= SIN_TAB[ang];
      cs <= COS_TAB[ang];
    end
    if (cmd.mul) begin
      ofs_x <= 33'(prod_x >>> 8);
      ofs_y <= 33'(prod_y >>> 8);
    end
    if (cmd.add) begin
      dx <= ((cmd.corner[1] == 1'b0) ? -hw_s : hw_s) + 35'(ofs_x);
      dy <= ((cmd.corner == 2'd1 || cmd.corner == 2'd2) ? hh_s : -hh_s) + 35'(ofs_y);
    end
    if (cmd.rot) begin
      p_xc <= dx * cs;
      p_ys <= dy * sn;
      p_xs <= dx * sn;
      p_yc <= dy * cs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (cmd.out_vtx || cmd.out_idx || cmd.out_flush) begin
      ovalid <= 1'b1;
    end else if (result.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_vtx || cmd.out_idx || cmd.out_flush) begin
      o_last <= cmd.last;
      o_x    <= '0;
      o_y    <= '0;
      o_z    <= '0;
      o_u    <= 1'b0;
      o_v    <= 1'b0;
      o_slot <= '0;
      o_tex  <= '0;
      o_cnt  <= '0;
      if (cmd.out_vtx) begin
        o_kind <= RK_VERTEX;
        o_x    <= sat_x;
        o_y    <= sat_y;
        o_z    <= pz;
        o_u    <= cmd.corner[1];
        o_v    <= ~(cmd.corner[1] ^ cmd.corner[0]);
        o_slot <= cmd.slot;
      end else if (cmd.out_idx) begin
        o_kind <= RK_INDEX;
        o_slot <= cmd.slot;
      end else begin
        o_kind <= RK_FLUSH;
        o_tex  <= cmd.flush_tex;
        o_cnt  <= cmd.flush_cnt;
      end
    end
  end

  assign result.valid         = ovalid;
  assign result.result_kind   = o_kind;
  assign result.vertex_x      = o_x;
  assign result.vertex_y      = o_y;
  assign result.vertex_z      = o_z;
  assign result.tex_u         = o_u;
  assign result.tex_v         = o_v;
  assign result.slot          = o_slot;
  assign result.batch_texture = o_tex;
  assign result.index_count   = o_cnt;
  assign result.last          = o_last;

endmodule

// ===== verif/tb_sprite_quad_batcher.sv =====
// Testbench for the sprite quad batcher: directed table, full batch, then random draws/offsets/flushes/unknown kinds.
// Depends on spqb_pkg, spqb_if and the sprite_quad_batcher RTL.
module tb_sprite_quad_batcher;
  import spqb_pkg::*;

  typedef struct {
    logic [1:0]                kind;
    logic [TEX_W-1:0]          tex;
    logic signed [COORD_W-1:0] px, py, pz, ox, oy;
    logic [15:0]               w, h, sc, rot;
    logic [1:0]                corner;
  } draw_item_t;

  typedef struct packed {
    logic [1:0]                rkind;
    logic signed [COORD_W-1:0] vx, vy, vz;
    logic                      u, v;
    logic [SLOT_W-1:0]         slot;
    logic [TEX_W-1:0]          btex;
    logic [CNT_W-1:0]          cnt;
    logic                      last;
  } vtx_result_t;

  // directed rows; has_exp marks rows with a typed-in first result
  typedef struct {
    draw_item_t  it;
    bit          has_exp;
    vtx_result_t exp;
  } stim_row_t;

  logic clk, rst;
  spqb_in_if  item_ch (clk);
  spqb_out_if res_ch (clk);

  sprite_quad_batcher DUT (.clk(clk), .rst(rst), .item(item_ch), .result(res_ch));

  vtx_result_t pending_results[$];
  int          n_mismatch;
  int          quads_open;
  logic [TEX_W-1:0] open_tex;
  longint      offs[8];
  int          send_idle_pct, recv_stall_pct;
  bit          hold_off;
  bit          press_go;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint floor_div_pow2(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat24(longint v);
    longint hi;
    hi = (longint'(1) << (COORD_W - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  // Q14 sine of a Q30 angle, own series
  function automatic longint sine_q14(longint ang);
    longint a, t, s;
    bit neg;
    a = ang;
    neg = 0;
    while (a >= Q30_TWO_PI) a -= Q30_TWO_PI;
    if (a > Q30_PI) begin
      a -= Q30_PI;
      neg = 1;
    end
    if (a > Q30_HALF_PI) a = Q30_PI - a;
    if (a < 0) a = 0;
    t = a;
    s = a;
    for (int k = 1; k <= 7; k++) begin
      t = (t * a) / Q30_ONE;
      t = (t * a) / Q30_ONE;
      t = t / (longint'(2 * k) * longint'(2 * k + 1));
      if (k % 2 == 1) s -= t;
      else s += t;
    end
    if (s < 0) s = 0;
    s = (s + 32768) >>> 16;
    return neg ? -s : s;
  endfunction

  function automatic vtx_result_t blank_result(logic [1:0] k);
    vtx_result_t r;
    r = '0;
    r.rkind = k;
    return r;
  endfunction

  task automatic close_batch();
    vtx_result_t r;
    r = blank_result(RK_FLUSH);
    r.btex = open_tex;
    r.cnt = CNT_W'(6 * quads_open);
    pending_results.push_back(r);
    quads_open = 0;
    open_tex = '0;
  endtask

  // work out the results of one accepted item and queue them
  task automatic predict_batch(draw_item_t it);
    vtx_result_t r;
    longint hw, hh, sn, cs, ang, dx, dy, rx, ry, sc;
    int q, nb;
    int pat[6];
    nb = pending_results.size();
    pat = '{0, 1, 2, 0, 2, 3};
    if (it.kind == IK_OFFSET) begin
      offs[2 * it.corner] = longint'(it.ox);
      offs[2 * it.corner + 1] = longint'(it.oy);
      return;
    end
    if (it.kind == IK_FLUSH) close_batch();
    else if (it.kind == IK_DRAW) begin
      if ((quads_open != 0 && open_tex != it.tex) || quads_open >= MAX_QUADS) close_batch();
      sc = longint'(it.sc);
      hw = (sc != 0 ? longint'(it.w) * sc : longint'(it.w) * 256) >>> 1;
      hh = (sc != 0 ? longint'(it.h) * sc : longint'(it.h) * 256) >>> 1;
      ang = (longint'(it.rot) * SINE_ENTRIES) >>> 16;
      ang = (ang * Q30_TWO_PI) / SINE_ENTRIES;
      sn = sine_q14(ang);
      cs = sine_q14(ang + Q30_HALF_PI);
      q = quads_open;
      for (int c = 0; c < 4; c++) begin
        dx = (c < 2 ? -hw : hw) + floor_div_pow2(offs[2 * c] * sc, 8);
        dy = ((c == 1 || c == 2) ? hh : -hh) + floor_div_pow2(offs[2 * c + 1] * sc, 8);
        rx = floor_div_pow2(dx * cs - dy * sn + 8192, 14) + longint'(it.px);
        ry = floor_div_pow2(dx * sn + dy * cs + 8192, 14) + longint'(it.py);
        r = blank_result(RK_VERTEX);
        r.vx = COORD_W'(sat24(rx));
        r.vy = COORD_W'(sat24(ry));
        r.vz = it.pz;
        r.u = (c >= 2);
        r.v = (c == 0 || c == 3);
        r.slot = SLOT_W'(4 * q + c);
        pending_results.push_back(r);
      end
      for (int i = 0; i < 6; i++) begin
        r = blank_result(RK_INDEX);
        r.slot = SLOT_W'(4 * q + pat[i]);
        pending_results.push_back(r);
      end
      open_tex = it.tex;
      quads_open = q + 1;
    end
    if (pending_results.size() > nb) pending_results[$].last = 1'b1;
  endtask

  function automatic draw_item_t mk(logic [1:0] k, int tex, int px, int py, int pz,
                                    int w, int h, int sc, int rot);
    draw_item_t it;
    it.kind = k; it.tex = 16'(tex);
    it.px = COORD_W'(px); it.py = COORD_W'(py); it.pz = COORD_W'(pz);
    it.w = 16'(w); it.h = 16'(h); it.sc = 16'(sc); it.rot = 16'(rot);
    it.corner = '0; it.ox = '0; it.oy = '0;
    return it;
  endfunction

  function automatic draw_item_t mk_off(logic [1:0] c, int ox, int oy);
    draw_item_t it;
    it = mk(IK_OFFSET, 65535, -1, -1, -1, 65535, 65535, 65535, 65535);
    it.corner = c; it.ox = COORD_W'(ox); it.oy = COORD_W'(oy);
    return it;
  endfunction

  function automatic draw_item_t rand_item();
    draw_item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it = mk(IK_DRAW, $urandom_range(1, 3), $urandom, $urandom, $urandom,
            $urandom_range(0, 64), $urandom_range(0, 64),
            $urandom_range(0, 1023), $urandom);
    it.corner = 2'($urandom); it.ox = 24'($urandom); it.oy = 24'($urandom);
    if (sel < 8) it.kind = IK_OFFSET;
    else if (sel < 14) it.kind = IK_FLUSH;
    else if (sel < 16) it.kind = IK_UNKNOWN;
    else if (sel < 26) begin
      it.tex = 16'($urandom); it.w = 16'($urandom); it.h = 16'($urandom);
      it.sc = 16'($urandom);
    end else if (sel < 40) begin
      it.px = COORD_W'($urandom_range(0, 4000) - 2000);
      it.py = COORD_W'($urandom_range(0, 4000) - 2000);
    end
    if (it.kind == IK_OFFSET && $urandom_range(0, 1)) begin
      it.ox = COORD_W'($urandom_range(0, 8000) - 4000);
      it.oy = COORD_W'($urandom_range(0, 8000) - 4000);
    end
    return it;
  endfunction

  // drive one transaction, predicting at acceptance; valid stays up for the next one
  task automatic send_item(draw_item_t it);
    if (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      item_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(1, 100) <= send_idle_pct);
    end
    item_ch.valid <= 1'b1;
    item_ch.kind <= it.kind; item_ch.texture_id <= it.tex;
    item_ch.pos_x <= it.px; item_ch.pos_y <= it.py; item_ch.pos_z <= it.pz;
    item_ch.size_w <= it.w; item_ch.size_h <= it.h;
    item_ch.scale <= it.sc; item_ch.rotation <= it.rot;
    item_ch.corner <= it.corner; item_ch.offset_x <= it.ox; item_ch.offset_y <= it.oy;
    do @(posedge clk); while (!item_ch.ready);
    predict_batch(it);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
  endtask

  // result side: stall at random, check each accepted transaction
  always @(posedge clk) begin
    vtx_result_t e, a;
    if (rst) res_ch.ready <= 1'b0;
    else begin
      if (res_ch.valid && res_ch.ready) begin
        a = '{rkind: res_ch.result_kind, vx: res_ch.vertex_x, vy: res_ch.vertex_y,
              vz: res_ch.vertex_z, u: res_ch.tex_u, v: res_ch.tex_v, slot: res_ch.slot,
              btex: res_ch.batch_texture, cnt: res_ch.index_count, last: res_ch.last};
        if (pending_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected transaction kind=%0d", a.rkind);
        end else begin
          e = pending_results.pop_front();
          if (a !== e) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch exp k%0d x%0d y%0d z%0d u%0d v%0d s%0d t%0d c%0d l%0d / got k%0d x%0d y%0d z%0d u%0d v%0d s%0d t%0d c%0d l%0d",
                e.rkind, e.vx, e.vy, e.vz, e.u, e.v, e.slot, e.btex, e.cnt, e.last,
                a.rkind, a.vx, a.vy, a.vz, a.u, a.v, a.slot, a.btex, a.cnt, a.last);
          end
        end
      end
      res_ch.ready <= !hold_off &&
                      !(recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct);
    end
  end

  // long hold-off while the sender keeps offering items
  initial begin
    int held;
    hold_off = 1'b0;
    wait (press_go);
    @(posedge clk);
    hold_off <= 1'b1;
    for (held = 0; held < 300; held++) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    stim_row_t rows[$];
    vtx_result_t ef;
    int phase_idle[4], phase_stall[4];
    n_mismatch = 0; quads_open = 0; open_tex = '0; press_go = 1'b0;
    foreach (offs[i]) offs[i] = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    item_ch.valid <= 1'b0;
    item_ch.kind <= IK_DRAW; item_ch.texture_id <= '0;
    item_ch.pos_x <= '0; item_ch.pos_y <= '0; item_ch.pos_z <= '0;
    item_ch.size_w <= '0; item_ch.size_h <= '0; item_ch.scale <= '0; item_ch.rotation <= '0;
    item_ch.corner <= '0; item_ch.offset_x <= '0; item_ch.offset_y <= '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // flush of empty batch right after reset
    ef = blank_result(RK_FLUSH);
    ef.last = 1'b1;
    rows.push_back('{mk(IK_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, ef});
    // unrotated unit quad at origin: LL corner at (-128,-128)
    ef = blank_result(RK_VERTEX);
    ef.vx = COORD_W'(-128); ef.vy = COORD_W'(-128); ef.v = 1'b1;
    rows.push_back('{mk(IK_DRAW, 5, 0, 0, 0, 1, 1, 0, 0), 1'b1, ef});
    // texture change closes a one-quad batch
    ef = blank_result(RK_FLUSH);
    ef.btex = 16'd5; ef.cnt = 11'd6;
    rows.push_back('{mk(IK_DRAW, 0, 0, 0, 0, 1, 1, 256, 0), 1'b1, ef});
    rows.push_back('{mk(IK_UNKNOWN, 1, 1, 1, 1, 1, 1, 1, 1), 1'b0, ef});
    rows.push_back('{mk_off(2'd0, 8388607, -8388608), 1'b0, ef});
    rows.push_back('{mk_off(2'd1, -8388608, 8388607), 1'b0, ef});
    rows.push_back('{mk_off(2'd2, 100, -100), 1'b0, ef});
    rows.push_back('{mk_off(2'd3, -256, 256), 1'b0, ef});
    rows.push_back('{mk(IK_DRAW, 65535, 8388607, -8388608, 8388607,
                        65535, 65535, 65535, 65535), 1'b0, ef});
    rows.push_back('{mk(IK_DRAW, 65535, -8388608, 8388607, -8388608,
                        65535, 0, 'h0100, 'h4000), 1'b0, ef});
    rows.push_back('{mk(IK_DRAW, 65535, 1000, -1000, 7, 3, 5, 'h0080, 'h8000), 1'b0, ef});
    rows.push_back('{mk(IK_DRAW, 65535, 0, 0, 0, 0, 65535, 0, 'hc000), 1'b0, ef});
    rows.push_back('{mk(IK_DRAW, 65535, 55, 66, 77, 10, 20, 'h0001, 'h2000), 1'b0, ef});
    rows.push_back('{mk(IK_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, ef});
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        // empty the queue so that the row's first result sits at its head
        drain();
        send_item(rows[i].it);
        if (pending_results.size() == 0 || pending_results[0] !== rows[i].exp) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("directed row %0d: first result differs", i);
        end
      end else begin
        send_item(rows[i].it);
      end
    end
    // full batch: seventeen draws of one texture force a self flush, under a long hold-off
    press_go = 1'b1;
    for (int i = 0; i < 17; i++)
      send_item(mk(IK_DRAW, 9, i * 256, 0, i, 4, 4, 'h0100, i * 4096));
    drain();
    phase_idle = '{0, 50, 0, 19};
    phase_stall = '{0, 0, 50, 19};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int i = 0; i < 38; i++) send_item(rand_item());
      drain();
    end
    if (n_mismatch == 0 && pending_results.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
